FILE: sv/nvdc_pkg.sv
// Package for the node visit depth counter.
// Holds the item codes, the queued command and node record types, and register indexes.
// No dependencies.
package nvdc_pkg;

	typedef enum logic [1:0] {
		FUNC_VISIT = 2'd0,
		FUNC_PATH  = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// Configuration register indexes
	localparam logic CFG_NODE_COUNT     = 1'b0;
	localparam logic CFG_COUNT_DISTINCT = 1'b1;

	localparam int QDEPTH = 2;

	typedef struct packed {
		func_t       op;
		logic        ok;
		logic [31:0] len;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	typedef struct packed {
		logic [31:0] mark;
		logic [31:0] distinct;
		logic [31:0] visit;
	} node_rec_t;

	typedef enum logic [1:0] {
		BK_CLEAR = 2'd0,
		BK_IDLE  = 2'd1,
		BK_EXEC  = 2'd2
	} back_state_t;

endpackage

FILE: sv/nvdc_front.sv
// Front stage: accepts requests, decodes the node id and range-checks it.
// Depends on nvdc_pkg.
module nvdc_front import nvdc_pkg::*; #(
	parameter int NODE_CAPACITY = 65536,
	parameter int AW            = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           func,
	input  logic signed [17:0]   node_id,
	input  logic [31:0]          seg_len,
	input  logic [16:0]          node_count,
	input  logic                 clearing,
	input  logic                 q_full,
	output logic                 q_push,
	output cmd_t                 q_cmd,
	output logic [AW-1:0]        q_addr
);

	localparam logic [24:0] CAP = 25'(NODE_CAPACITY);

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [AW-1:0] addr_s1;

	logic        accept;
	logic [17:0] mag;
	logic [24:0] addr_full;
	logic        ok;
	logic        keep;
	func_t       op;

	always_comb begin
		op        = func_t'(func);
		mag       = node_id[17] ? 18'(~node_id + 18'sd1) : 18'(node_id);
		ok        = (mag != 18'd0) && (mag <= {1'b0, node_count}) && ({7'b0, mag} <= CAP);
		addr_full = {7'b0, mag} - 25'd1;
		// drop unused codes and visits to nodes out of range
		keep      = (op == FUNC_PATH) || (op == FUNC_READ) || ((op == FUNC_VISIT) && ok);
	end

	assign busy   = clearing || (valid_s1 && q_full);
	assign accept = start && !busy;
	assign q_push = valid_s1 && !q_full;
	assign q_cmd  = cmd_s1;
	assign q_addr = addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op  <= op;
			cmd_s1.ok  <= ok;
			cmd_s1.len <= seg_len;
			addr_s1    <= addr_full[AW-1:0];
		end
	end

endmodule

FILE: sv/nvdc_queue.sv
// Small FIFO between the front and back stages.
// Depends on nvdc_pkg for its depth.
module nvdc_queue import nvdc_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         empty,
	output logic         full
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	logic [W-1:0]  slot_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty = (count_q == CW'(0));
	assign full  = (count_q == CW'(QDEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

FILE: sv/nvdc_back.sv
// Back stage: owns the node record memory, runs the clearing pass after reset,
// performs read-modify-write per visit, path stamping, totals and read results.
// Depends on nvdc_pkg.
module nvdc_back import nvdc_pkg::*; #(
	parameter int NODE_CAPACITY = 65536,
	parameter int AW            = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          count_distinct,
	input  logic          q_empty,
	input  cmd_t          q_cmd,
	input  logic [AW-1:0] q_addr,
	output logic          q_pop,
	output logic          clearing,
	output logic          done,
	output logic [31:0]   node_depth,
	output logic [31:0]   node_distinct,
	output logic          id_valid,
	output logic [47:0]   step_sum,
	output logic [63:0]   bp_sum
);

	node_rec_t   node_mem_q [NODE_CAPACITY];
	node_rec_t   rd_q;

	back_state_t state_q, state_d;
	logic [AW-1:0] clr_addr_q;
	func_t       op_q;
	logic        ok_q;
	logic [31:0] len_q;
	logic [AW-1:0] addr_q;
	logic [31:0] stamp_q, stamp_d;
	logic [47:0] step_q, step_d;
	logic [63:0] bp_q, bp_d;

	logic          load_cur;
	logic          res_d;
	logic          we;
	logic [AW-1:0] wa;
	node_rec_t     wd;
	node_rec_t     rec_upd;
	logic [64:0]   bp_add;

	logic        done_q;
	logic [31:0] depth_q;
	logic [31:0] distinct_q;
	logic        valid_q;

	always_comb begin
		rec_upd       = rd_q;
		rec_upd.visit = (rd_q.visit == '1) ? rd_q.visit : rd_q.visit + 32'd1;
		if (count_distinct && (rd_q.mark != stamp_q)) begin
			rec_upd.mark     = stamp_q;
			rec_upd.distinct = (rd_q.distinct == '1) ? rd_q.distinct
			                                         : rd_q.distinct + 32'd1;
		end
		bp_add = {1'b0, bp_q} + {33'b0, len_q};
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_cur = 1'b0;
		res_d    = 1'b0;
		we       = 1'b0;
		wa       = addr_q;
		wd       = rec_upd;
		stamp_d  = stamp_q;
		step_d   = step_q;
		bp_d     = bp_q;
		case (state_q)
			BK_CLEAR: begin
				we = 1'b1;
				wa = clr_addr_q;
				wd = '0;
				if (clr_addr_q == AW'(NODE_CAPACITY - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_cmd.op == FUNC_PATH) begin
						stamp_d = stamp_q + 32'd1;
					end else begin
						load_cur = 1'b1;
						state_d  = BK_EXEC;
					end
				end
			end
			BK_EXEC: begin
				state_d = BK_IDLE;
				if (op_q == FUNC_VISIT) begin
					we     = 1'b1;
					step_d = (step_q == '1) ? step_q : step_q + 48'd1;
					bp_d   = bp_add[64] ? '1 : bp_add[63:0];
				end else begin
					res_d = 1'b1;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			stamp_q    <= '0;
			step_q     <= '0;
			bp_q       <= '0;
			done_q     <= 1'b0;
		end else begin
			if (state_q == BK_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			stamp_q <= stamp_d;
			step_q  <= step_d;
			bp_q    <= bp_d;
			done_q  <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_cur) begin
			op_q   <= q_cmd.op;
			ok_q   <= q_cmd.ok;
			len_q  <= q_cmd.len;
			addr_q <= q_addr;
		end
		if (res_d) begin
			depth_q    <= ok_q ? rd_q.visit : '0;
			distinct_q <= ok_q ? rd_q.distinct : '0;
			valid_q    <= ok_q;
		end
	end

	// Record memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			node_mem_q[wa] <= wd;
		end
		rd_q <= node_mem_q[q_addr];
	end

	assign clearing      = (state_q == BK_CLEAR);
	assign done          = done_q;
	assign node_depth    = depth_q;
	assign node_distinct = distinct_q;
	assign id_valid      = valid_q;
	assign step_sum      = step_q;
	assign bp_sum        = bp_q;

endmodule

FILE: sv/node_visit_depth_counter.sv
// Node visit depth counter: top level.
// Depends on nvdc_pkg, nvdc_front, nvdc_queue and nvdc_back.
//
// Usage:
//   Requests enter on start/busy: a request is taken at a clock edge with start high
//   and busy low. func selects visit (0), start new path (1) or read (2); node_id is
//   signed, its magnitude names the node, and seg_len is the segment length of a visit.
//   A read produces one result on node_depth, node_distinct, id_valid, step_sum and
//   bp_sum, shown for exactly one cycle with done high. The receiver cannot stall;
//   it must take the result in that cycle. Visits and path starts give no result.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Index 0 is node_count, index 1 is count_distinct. Write only while
//   no request is pending.
//   Read path: decode register, queue, back stage EXEC state, then the done register.
//   The back stage pops a visit or read in IDLE, where the memory read is issued, and
//   in EXEC writes a visit back or registers a read's result; a path start needs IDLE
//   alone. Nothing is popped in EXEC. A 2-entry queue after the decode register absorbs
//   short bursts; busy rises when the queue is full and the decode register still holds
//   a request. Reset: totals, stamp, done, state, queue and config registers are cleared;
//   result registers are not. Then the back stage clears the record memory, one entry
//   a cycle over all NODE_CAPACITY entries; busy stays high for the whole pass.
module node_visit_depth_counter import nvdc_pkg::*; #(
	parameter int NODE_CAPACITY = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          func,
	input  logic signed [17:0]  node_id,
	input  logic [31:0]         seg_len,
	output logic                done,
	output logic [31:0]         node_depth,
	output logic [31:0]         node_distinct,
	output logic                id_valid,
	output logic [47:0]         step_sum,
	output logic [63:0]         bp_sum,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [16:0]         cfg_data
);

	localparam int AW = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
	localparam int QW = CMD_W + AW;

	// configuration registers
	logic [16:0] node_count_q;
	logic        count_distinct_q;

	// front to queue
	logic          push;
	cmd_t          push_cmd;
	logic [AW-1:0] push_addr;

	// queue to back
	logic [QW-1:0] q_head;
	logic          q_empty;
	logic          q_full;
	logic          pop;
	logic          clearing;

	assign cfg_ready = 1'b1;

	// Take configuration writes at any time; the index picks the register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q     <= '0;
			count_distinct_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NODE_COUNT:     node_count_q     <= cfg_data;
				CFG_COUNT_DISTINCT: count_distinct_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Decode and range-check; drop requests that change nothing.
	nvdc_front #(
		.NODE_CAPACITY(NODE_CAPACITY),
		.AW           (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.node_id   (node_id),
		.seg_len   (seg_len),
		.node_count(node_count_q),
		.clearing  (clearing),
		.q_full    (q_full),
		.q_push    (push),
		.q_cmd     (push_cmd),
		.q_addr    (push_addr)
	);

	// Hold decoded requests until the back stage is free.
	nvdc_queue #(
		.W(QW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   ({push_cmd, push_addr}),
		.pop   (pop),
		.head  (q_head),
		.empty (q_empty),
		.full  (q_full)
	);

	// Update node records and totals, and emit read results.
	nvdc_back #(
		.NODE_CAPACITY(NODE_CAPACITY),
		.AW           (AW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.count_distinct(count_distinct_q),
		.q_empty       (q_empty),
		.q_cmd         (cmd_t'(q_head[QW-1:AW])),
		.q_addr        (q_head[AW-1:0]),
		.q_pop         (pop),
		.clearing      (clearing),
		.done          (done),
		.node_depth    (node_depth),
		.node_distinct (node_distinct),
		.id_valid      (id_valid),
		.step_sum      (step_sum),
		.bp_sum        (bp_sum)
	);

endmodule
